>>> hdl/tosw_pkg.sv
// Shared constants, codes and controller/datapath interface types of the scanline walker.
package tosw_pkg;

    localparam int SCREEN_COLS = 84;
    localparam int SCREEN_ROWS = 48;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 6;
    // Signed column difference and the quotient of a slope division.
    localparam int DX_W    = COL_W + 1;
    localparam int PROD_W  = DX_W + ROW_W + 1;
    localparam int DIV_STEPS = COL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [COL_W-1:0] COL_MAX = COL_W'(SCREEN_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(SCREEN_ROWS - 1);

    typedef enum logic [1:0] {
        DIV_LONG    = 2'd0,
        DIV_SHORT_A = 2'd1,
        DIV_SHORT_B = 2'd2
    } div_sel_t;

    typedef enum logic [1:0] {
        EMIT_EDGE = 2'd0,
        EMIT_VERT = 2'd1,
        EMIT_SPAN = 2'd2,
        EMIT_FLAT = 2'd3
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      prod;
        logic      div_start;
        div_sel_t  div_sel;
        logic      emit;
        logic      step;
        emit_sel_t emit_sel;
    } cmd_t;

    typedef struct packed {
        logic same_col;
        logic flat_all;
        logic flat_top;
        logic flat_bot;
        logic row_end;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

>>> hdl/tosw_divider.sv
// Iterative signed floor divider for slope setup, one quotient bit per cycle.
module tosw_divider (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [tosw_pkg::DX_W-1:0]  num,
    input  logic        [tosw_pkg::ROW_W-1:0] den,
    output logic                              done,
    output logic signed [tosw_pkg::DX_W-1:0]  quo,
    output logic        [tosw_pkg::ROW_W-1:0] rem
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [tosw_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [tosw_pkg::COL_W-1:0]         quo_reg;
    logic [tosw_pkg::ROW_W-1:0]         rem_reg;
    logic [tosw_pkg::ROW_W-1:0]         den_reg;
    logic                               neg_reg;

    logic [tosw_pkg::COL_W-1:0]         mag;
    logic [tosw_pkg::ROW_W:0]           trial;
    logic                               fit;
    logic [tosw_pkg::ROW_W-1:0]         rem_next;

    assign mag      = num[tosw_pkg::DX_W-1] ? tosw_pkg::COL_W'(-num)
                                            : tosw_pkg::COL_W'(num);
    assign trial    = {rem_reg, quo_reg[tosw_pkg::COL_W-1]};
    assign fit      = trial >= {1'b0, den_reg};
    assign rem_next = fit ? tosw_pkg::ROW_W'(trial - {1'b0, den_reg})
                          : trial[tosw_pkg::ROW_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == tosw_pkg::DIV_CNT_W'(tosw_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= mag;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[tosw_pkg::DX_W-1];
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[tosw_pkg::COL_W-2:0], fit};
            rem_reg <= rem_next;
        end
    end

    // A negative dividend with a nonzero remainder rounds one further down.
    always_comb begin
        if (!neg_reg) begin
            quo = $signed({1'b0, quo_reg});
            rem = rem_reg;
        end else if (rem_reg == '0) begin
            quo = -$signed({1'b0, quo_reg});
            rem = '0;
        end else begin
            quo = -$signed({1'b0, quo_reg}) - tosw_pkg::DX_W'(1);
            rem = den_reg - rem_reg;
        end
    end

    assign done = done_reg;

endmodule

>>> hdl/tosw_datapath.sv
// Vertex sort, slope setup, edge stepping and result register of the scanline walker.
module tosw_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tosw_pkg::cmd_t                    cmd,
    output tosw_pkg::status_t                 status,
    input  logic        [tosw_pkg::COL_W-1:0] s_vertex_a_x,
    input  logic        [tosw_pkg::ROW_W-1:0] s_vertex_a_y,
    input  logic        [tosw_pkg::COL_W-1:0] s_vertex_b_x,
    input  logic        [tosw_pkg::ROW_W-1:0] s_vertex_b_y,
    input  logic        [tosw_pkg::COL_W-1:0] s_vertex_c_x,
    input  logic        [tosw_pkg::ROW_W-1:0] s_vertex_c_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic        [tosw_pkg::ROW_W-1:0] m_row,
    output logic        [tosw_pkg::COL_W-1:0] m_x_left,
    output logic        [tosw_pkg::COL_W-1:0] m_x_right,
    output logic                              m_kind,
    output logic                              m_last
);

    typedef struct packed {
        logic [tosw_pkg::COL_W-1:0] x;
        logic [tosw_pkg::ROW_W-1:0] y;
    } vtx_t;

    typedef logic signed [tosw_pkg::DX_W-1:0]   dx_t;
    typedef logic signed [tosw_pkg::PROD_W-1:0] prod_t;

    function automatic vtx_t clamp_vtx(logic [tosw_pkg::COL_W-1:0] x,
                                       logic [tosw_pkg::ROW_W-1:0] y);
        vtx_t v;
        v.x = (x > tosw_pkg::COL_MAX) ? tosw_pkg::COL_MAX : x;
        v.y = (y > tosw_pkg::ROW_MAX) ? tosw_pkg::ROW_MAX : y;
        return v;
    endfunction

    function automatic logic after(vtx_t a, vtx_t b);
        return (a.y > b.y) || ((a.y == b.y) && (a.x > b.x));
    endfunction

    vtx_t  in0, in1, in2, s1a, s1b, s2a, s2b, srt0, srt1;
    vtx_t  v0_reg, v1_reg, v2_reg;

    dx_t   dx01, dx02, dx12;
    logic [tosw_pkg::ROW_W-1:0] dy01, dy02, dy12;
    prod_t prod_a_reg, prod_b_reg;
    logic  long_right;

    logic  div_done;
    dx_t   div_quo, div_num;
    logic [tosw_pkg::ROW_W-1:0] div_rem, div_den;

    dx_t   lq_reg, aq_reg, bq_reg;
    logic [tosw_pkg::ROW_W-1:0] lrs_reg, ars_reg, brs_reg;

    logic [tosw_pkg::ROW_W-1:0] y_reg, lr_reg, sr_reg;
    logic [tosw_pkg::COL_W-1:0] lx_reg, sx_reg;
    logic                       short_b_reg;

    logic [tosw_pkg::ROW_W:0]   lsum, ssum;
    logic                       lwrap, swrap;
    dx_t                        sq;
    logic [tosw_pkg::ROW_W-1:0] srs, sdy;
    logic [tosw_pkg::ROW_W-1:0] y_inc;

    logic                       m_valid_reg;
    logic [tosw_pkg::ROW_W-1:0] row_reg, row_next;
    logic [tosw_pkg::COL_W-1:0] xl_reg, xl_next, xr_reg, xr_next;
    logic                       kind_reg, kind_next, last_reg, last_next;

    // Three compare-exchange steps order the corners by row, then column.
    always_comb begin
        in0 = clamp_vtx(s_vertex_a_x, s_vertex_a_y);
        in1 = clamp_vtx(s_vertex_b_x, s_vertex_b_y);
        in2 = clamp_vtx(s_vertex_c_x, s_vertex_c_y);
        s1a = after(in0, in1) ? in1 : in0;
        s1b = after(in0, in1) ? in0 : in1;
        s2a = after(s1b, in2) ? in2 : s1b;
        s2b = after(s1b, in2) ? s1b : in2;
        srt0 = after(s1a, s2a) ? s2a : s1a;
        srt1 = after(s1a, s2a) ? s1a : s2a;
    end

    assign dx01 = $signed({1'b0, v1_reg.x}) - $signed({1'b0, v0_reg.x});
    assign dx02 = $signed({1'b0, v2_reg.x}) - $signed({1'b0, v0_reg.x});
    assign dx12 = $signed({1'b0, v2_reg.x}) - $signed({1'b0, v1_reg.x});
    assign dy01 = v1_reg.y - v0_reg.y;
    assign dy02 = v2_reg.y - v0_reg.y;
    assign dy12 = v2_reg.y - v1_reg.y;

    assign long_right = prod_a_reg > prod_b_reg;

    always_comb begin
        case (cmd.div_sel)
            tosw_pkg::DIV_LONG: begin
                div_num = dx02;
                div_den = dy02;
            end
            tosw_pkg::DIV_SHORT_A: begin
                div_num = dx01;
                div_den = dy01;
            end
            default: begin
                div_num = dx12;
                div_den = dy12;
            end
        endcase
    end

    tosw_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // Each edge advances by its whole quotient per row and carries one extra
    // column whenever the running remainder reaches the edge height.
    assign lsum  = {1'b0, lr_reg} + {1'b0, lrs_reg};
    assign lwrap = lsum >= {1'b0, dy02};
    assign sq    = short_b_reg ? bq_reg  : aq_reg;
    assign srs   = short_b_reg ? brs_reg : ars_reg;
    assign sdy   = short_b_reg ? dy12    : dy01;
    assign ssum  = {1'b0, sr_reg} + {1'b0, srs};
    assign swrap = ssum >= {1'b0, sdy};
    assign y_inc = y_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v0_reg      <= srt0;
            v1_reg      <= srt1;
            v2_reg      <= s2b;
            y_reg       <= srt0.y;
            lx_reg      <= srt0.x;
            lr_reg      <= '0;
            sr_reg      <= '0;
            short_b_reg <= (srt0.y == srt1.y);
            sx_reg      <= (srt0.y == srt1.y) ? srt1.x : srt0.x;
        end else if (cmd.step) begin
            y_reg <= y_inc;
            if (lwrap) begin
                lx_reg <= tosw_pkg::COL_W'($signed({2'b0, lx_reg}) + lq_reg + 1'b1);
                lr_reg <= tosw_pkg::ROW_W'(lsum - {1'b0, dy02});
            end else begin
                lx_reg <= tosw_pkg::COL_W'($signed({2'b0, lx_reg}) + lq_reg);
                lr_reg <= lsum[tosw_pkg::ROW_W-1:0];
            end
            if (!short_b_reg && (y_inc == v1_reg.y)) begin
                short_b_reg <= 1'b1;
                sx_reg      <= v1_reg.x;
                sr_reg      <= '0;
            end else if (swrap) begin
                sx_reg <= tosw_pkg::COL_W'($signed({2'b0, sx_reg}) + sq + 1'b1);
                sr_reg <= tosw_pkg::ROW_W'(ssum - {1'b0, sdy});
            end else begin
                sx_reg <= tosw_pkg::COL_W'($signed({2'b0, sx_reg}) + sq);
                sr_reg <= ssum[tosw_pkg::ROW_W-1:0];
            end
        end
        if (cmd.prod) begin
            prod_a_reg <= $signed({1'b0, dy01}) * dx02;
            prod_b_reg <= $signed({1'b0, dy02}) * dx01;
        end
        if (div_done) begin
            case (cmd.div_sel)
                tosw_pkg::DIV_LONG: begin
                    lq_reg  <= div_quo;
                    lrs_reg <= div_rem;
                end
                tosw_pkg::DIV_SHORT_A: begin
                    aq_reg  <= div_quo;
                    ars_reg <= div_rem;
                end
                default: begin
                    bq_reg  <= div_quo;
                    brs_reg <= div_rem;
                end
            endcase
        end
    end

    always_comb begin
        row_next  = y_reg;
        xl_next   = long_right ? sx_reg : lx_reg;
        xr_next   = long_right ? lx_reg : sx_reg;
        kind_next = 1'b0;
        last_next = (y_reg == v2_reg.y);
        unique case (cmd.emit_sel)
            tosw_pkg::EMIT_EDGE: begin
            end
            tosw_pkg::EMIT_VERT: begin
                xl_next = v0_reg.x;
                xr_next = v0_reg.x;
            end
            tosw_pkg::EMIT_SPAN: begin
                row_next  = v0_reg.y;
                xl_next   = v0_reg.x;
                xr_next   = v2_reg.x;
                kind_next = 1'b1;
                last_next = 1'b1;
            end
            tosw_pkg::EMIT_FLAT: begin
                kind_next = 1'b1;
                last_next = 1'b0;
                if (v0_reg.y == v1_reg.y) begin
                    row_next = v0_reg.y;
                    xl_next  = v0_reg.x;
                    xr_next  = v1_reg.x;
                end else begin
                    row_next = v1_reg.y;
                    xl_next  = v1_reg.x;
                    xr_next  = v2_reg.x;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            row_reg  <= row_next;
            xl_reg   <= xl_next;
            xr_reg   <= xr_next;
            kind_reg <= kind_next;
            last_reg <= last_next;
        end
    end

    assign status.same_col = (v0_reg.x == v1_reg.x) && (v0_reg.x == v2_reg.x);
    assign status.flat_all = (v0_reg.y == v2_reg.y);
    assign status.flat_top = (v0_reg.y == v1_reg.y);
    assign status.flat_bot = (v1_reg.y == v2_reg.y);
    assign status.row_end  = (y_reg == v2_reg.y);
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_row     = row_reg;
    assign m_x_left  = xl_reg;
    assign m_x_right = xr_reg;
    assign m_kind    = kind_reg;
    assign m_last    = last_reg;

endmodule

>>> hdl/tosw_ctrl.sv
// Sequencing state machine of the scanline walker.
module tosw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tosw_pkg::status_t status,
    output tosw_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_PROD     = 8'b0000_0010,
        ST_DIV_GO   = 8'b0000_0100,
        ST_DIV_WAIT = 8'b0000_1000,
        ST_VERT     = 8'b0001_0000,
        ST_SPAN     = 8'b0010_0000,
        ST_FLAT     = 8'b0100_0000,
        ST_WALK     = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    tosw_pkg::div_sel_t  sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= tosw_pkg::DIV_LONG;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        s_ready       = 1'b0;
        cmd.load      = 1'b0;
        cmd.prod      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = sel_reg;
        cmd.emit      = 1'b0;
        cmd.step      = 1'b0;
        cmd.emit_sel  = tosw_pkg::EMIT_EDGE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.prod = 1'b1;
                sel_next = tosw_pkg::DIV_LONG;
                if (status.same_col) begin
                    state_next = ST_VERT;
                end else if (status.flat_all) begin
                    state_next = ST_SPAN;
                end else begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    case (sel_reg)
                        tosw_pkg::DIV_LONG: begin
                            sel_next   = tosw_pkg::DIV_SHORT_A;
                            state_next = ST_DIV_GO;
                        end
                        tosw_pkg::DIV_SHORT_A: begin
                            sel_next   = tosw_pkg::DIV_SHORT_B;
                            state_next = ST_DIV_GO;
                        end
                        default: begin
                            sel_next   = tosw_pkg::DIV_LONG;
                            state_next = (status.flat_top || status.flat_bot) ? ST_FLAT
                                                                              : ST_WALK;
                        end
                    endcase
                end
            end
            ST_VERT: begin
                cmd.emit_sel = tosw_pkg::EMIT_VERT;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.step = 1'b1;
                    if (status.row_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SPAN: begin
                cmd.emit_sel = tosw_pkg::EMIT_SPAN;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLAT: begin
                cmd.emit_sel = tosw_pkg::EMIT_FLAT;
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.emit_sel = tosw_pkg::EMIT_EDGE;
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.step = 1'b1;
                    if (status.row_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/triangle_outline_scanline_walker.sv
// Top level of the triangle outline scanline walker.
//
//   channel | direction | beat contents
//   s_      | in        | three corners: vertex_{a,b,c}_{x,y}
//   m_      | out       | row, x_left, x_right, kind, last
//
// A triangle is accepted and set up, then takes three slope divisions on the
// shared divider, then its result beats: one per row, plus one for a flat edge.
// Triangles in one column or one row skip the divisions. Reset is synchronous and
// active low and clears the controller and the result valid. A stalled m_ready
// holds the walk in place; a new triangle is taken once the last beat sits in the
// result register.
module triangle_outline_scanline_walker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic        [tosw_pkg::COL_W-1:0] s_vertex_a_x,
    input  logic        [tosw_pkg::ROW_W-1:0] s_vertex_a_y,
    input  logic        [tosw_pkg::COL_W-1:0] s_vertex_b_x,
    input  logic        [tosw_pkg::ROW_W-1:0] s_vertex_b_y,
    input  logic        [tosw_pkg::COL_W-1:0] s_vertex_c_x,
    input  logic        [tosw_pkg::ROW_W-1:0] s_vertex_c_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic        [tosw_pkg::ROW_W-1:0] m_row,
    output logic        [tosw_pkg::COL_W-1:0] m_x_left,
    output logic        [tosw_pkg::COL_W-1:0] m_x_right,
    output logic                              m_kind,
    output logic                              m_last
);

    tosw_pkg::cmd_t    cmd;
    tosw_pkg::status_t status;

    tosw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tosw_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_vertex_a_x (s_vertex_a_x),
        .s_vertex_a_y (s_vertex_a_y),
        .s_vertex_b_x (s_vertex_b_x),
        .s_vertex_b_y (s_vertex_b_y),
        .s_vertex_c_x (s_vertex_c_x),
        .s_vertex_c_y (s_vertex_c_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row        (m_row),
        .m_x_left     (m_x_left),
        .m_x_right    (m_x_right),
        .m_kind       (m_kind),
        .m_last       (m_last)
    );

endmodule

>>> sim/tosw_outline_checker.sv
// Checker that watches both channels of the scanline walker, predicts the outline beats and compares them.
`timescale 1ns / 100ps

module tosw_outline_checker
    import tosw_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [COL_W-1:0] s_vertex_a_x,
    input  logic [ROW_W-1:0] s_vertex_a_y,
    input  logic [COL_W-1:0] s_vertex_b_x,
    input  logic [ROW_W-1:0] s_vertex_b_y,
    input  logic [COL_W-1:0] s_vertex_c_x,
    input  logic [ROW_W-1:0] s_vertex_c_y,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [ROW_W-1:0] m_row,
    input  logic [COL_W-1:0] m_x_left,
    input  logic [COL_W-1:0] m_x_right,
    input  logic             m_kind,
    input  logic             m_last,
    output int               fail_count,
    output int               outstanding,
    output int               beats_checked
);

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] x_left;
        logic [COL_W-1:0] x_right;
        logic             kind;
        logic             last;
    } outline_beat_t;

    outline_beat_t outline_q[$];
    int            mismatch_total = 0;
    int            compared_total = 0;

    assign fail_count    = mismatch_total;
    assign beats_checked = compared_total;

    initial outstanding = 0;

    // Rounds toward minus infinity; an edge with no height contributes nothing.
    function automatic int floor_quot(input int num, input int den);
        int q;
        if (den <= 0) begin
            return 0;
        end
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic outline_beat_t make_beat(input int row, input int xl, input int xr,
                                                input bit kind);
        outline_beat_t b;
        b.row     = ROW_W'(row);
        b.x_left  = COL_W'(xl);
        b.x_right = COL_W'(xr);
        b.kind    = kind;
        b.last    = 1'b0;
        return b;
    endfunction

    function automatic void predict_outline(
        input logic [COL_W-1:0] ax, input logic [ROW_W-1:0] ay,
        input logic [COL_W-1:0] bx, input logic [ROW_W-1:0] by,
        input logic [COL_W-1:0] cx, input logic [ROW_W-1:0] cy
    );
        outline_beat_t beats[0:SCREEN_ROWS+1];
        int  px[3];
        int  py[3];
        int  i, j, t, n, y;
        int  x0, y0, x1, y1, x2, y2;
        int  lo, hi, long_x, short_x;
        bit  long_right;
        n = 0;
        px[0] = (ax > COL_MAX) ? COL_MAX : ax;
        px[1] = (bx > COL_MAX) ? COL_MAX : bx;
        px[2] = (cx > COL_MAX) ? COL_MAX : cx;
        py[0] = (ay > ROW_MAX) ? ROW_MAX : ay;
        py[1] = (by > ROW_MAX) ? ROW_MAX : by;
        py[2] = (cy > ROW_MAX) ? ROW_MAX : cy;
        // Order the corners by row, ties broken by column.
        for (i = 0; i < 2; i++) begin
            for (j = 0; j < 2 - i; j++) begin
                if (py[j] > py[j+1] || (py[j] == py[j+1] && px[j] > px[j+1])) begin
                    t = px[j]; px[j] = px[j+1]; px[j+1] = t;
                    t = py[j]; py[j] = py[j+1]; py[j+1] = t;
                end
            end
        end
        x0 = px[0]; y0 = py[0];
        x1 = px[1]; y1 = py[1];
        x2 = px[2]; y2 = py[2];

        if (x0 == x1 && x0 == x2) begin
            for (y = y0; y <= y2; y++) begin
                beats[n] = make_beat(y, x0, x0, 1'b0);
                n++;
            end
        end else if (y0 == y2) begin
            lo = x0;
            hi = x0;
            if (x1 < lo) lo = x1;
            if (x2 < lo) lo = x2;
            if (x1 > hi) hi = x1;
            if (x2 > hi) hi = x2;
            beats[n] = make_beat(y0, lo, hi, 1'b1);
            n++;
        end else begin
            long_right = (y1 - y0) * (x2 - x0) > (y2 - y0) * (x1 - x0);
            if (y0 == y1) begin
                beats[n] = make_beat(y0, x0, x1, 1'b1);
                n++;
            end else if (y1 == y2) begin
                beats[n] = make_beat(y1, (x1 < x2) ? x1 : x2, (x1 < x2) ? x2 : x1, 1'b1);
                n++;
            end
            for (y = y0; y <= y2; y++) begin
                long_x = x0 + floor_quot((y - y0) * (x2 - x0), y2 - y0);
                if (y < y1) begin
                    short_x = x0 + floor_quot((y - y0) * (x1 - x0), y1 - y0);
                end else begin
                    short_x = x1 + floor_quot((y - y1) * (x2 - x1), y2 - y1);
                end
                if (long_right) begin
                    beats[n] = make_beat(y, short_x, long_x, 1'b0);
                end else begin
                    beats[n] = make_beat(y, long_x, short_x, 1'b0);
                end
                n++;
            end
        end
        beats[n-1].last = 1'b1;
        for (i = 0; i < n; i++) begin
            outline_q.push_back(beats[i]);
        end
    endfunction

    always @(posedge aclk) begin : watch
        outline_beat_t want;
        if (!aresetn) begin
            outline_q.delete();
            outstanding <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_outline(s_vertex_a_x, s_vertex_a_y, s_vertex_b_x, s_vertex_b_y,
                                s_vertex_c_x, s_vertex_c_y);
            end
            if (m_valid && m_ready) begin
                if (outline_q.size() == 0) begin
                    $error("outline beat with no triangle pending: row %0d, x_left %0d",
                           m_row, m_x_left);
                    mismatch_total++;
                end else begin
                    want = outline_q.pop_front();
                    compared_total++;
                    if (m_row !== want.row) begin
                        $error("row: expected %0d, got %0d", want.row, m_row);
                        mismatch_total++;
                    end
                    if (m_x_left !== want.x_left) begin
                        $error("x_left: expected %0d, got %0d", want.x_left, m_x_left);
                        mismatch_total++;
                    end
                    if (m_x_right !== want.x_right) begin
                        $error("x_right: expected %0d, got %0d", want.x_right, m_x_right);
                        mismatch_total++;
                    end
                    if (m_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_kind);
                        mismatch_total++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, m_last);
                        mismatch_total++;
                    end
                end
            end
            outstanding <= outline_q.size();
        end
    end

endmodule

>>> sim/triangle_outline_scanline_walker_tb.sv
// Testbench top of the scanline walker: drives triangles, pulls outline beats and gives the verdict.
`timescale 1ns / 100ps

module triangle_outline_scanline_walker_tb;
    import tosw_pkg::*;

    logic             aclk;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic [COL_W-1:0] s_vertex_a_x = '0;
    logic [ROW_W-1:0] s_vertex_a_y = '0;
    logic [COL_W-1:0] s_vertex_b_x = '0;
    logic [ROW_W-1:0] s_vertex_b_y = '0;
    logic [COL_W-1:0] s_vertex_c_x = '0;
    logic [ROW_W-1:0] s_vertex_c_y = '0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic [ROW_W-1:0] m_row;
    logic [COL_W-1:0] m_x_left;
    logic [COL_W-1:0] m_x_right;
    logic             m_kind;
    logic             m_last;

    int fail_count;
    int outstanding;
    int beats_checked;
    int send_idle_pct = 30;
    int recv_idle_pct = 62;
    int sent_count    = 0;

    triangle_outline_scanline_walker u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_vertex_a_x (s_vertex_a_x),
        .s_vertex_a_y (s_vertex_a_y),
        .s_vertex_b_x (s_vertex_b_x),
        .s_vertex_b_y (s_vertex_b_y),
        .s_vertex_c_x (s_vertex_c_x),
        .s_vertex_c_y (s_vertex_c_y),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row        (m_row),
        .m_x_left     (m_x_left),
        .m_x_right    (m_x_right),
        .m_kind       (m_kind),
        .m_last       (m_last)
    );

    tosw_outline_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vertex_a_x  (s_vertex_a_x),
        .s_vertex_a_y  (s_vertex_a_y),
        .s_vertex_b_x  (s_vertex_b_x),
        .s_vertex_b_y  (s_vertex_b_y),
        .s_vertex_c_x  (s_vertex_c_x),
        .s_vertex_c_y  (s_vertex_c_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row         (m_row),
        .m_x_left      (m_x_left),
        .m_x_right     (m_x_right),
        .m_kind        (m_kind),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .beats_checked (beats_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #8_000_000;
        $display("triangle_outline_scanline_walker regression: fail");
        $finish;
    end

    task automatic send_tri(input int ax, input int ay, input int bx, input int by,
                            input int cx, input int cy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_vertex_a_x <= COL_W'(ax);
        s_vertex_a_y <= ROW_W'(ay);
        s_vertex_b_x <= COL_W'(bx);
        s_vertex_b_y <= ROW_W'(by);
        s_vertex_c_x <= COL_W'(cx);
        s_vertex_c_y <= ROW_W'(cy);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    // Mostly on-screen triangles of every shape, with some lines, points and
    // corners past the screen edge mixed in.
    task automatic send_random_tri();
        int pick, i, j, base_x, base_y, step_x, step_y;
        int c[3];
        int r[3];
        pick = $urandom_range(99);
        for (i = 0; i < 3; i++) begin
            c[i] = $urandom_range(SCREEN_COLS - 1);
            r[i] = $urandom_range(SCREEN_ROWS - 1);
        end
        if (pick >= 40 && pick < 55) begin
            base_x = $urandom_range(SCREEN_COLS - 1);
            base_y = $urandom_range(SCREEN_ROWS - 1);
            for (i = 0; i < 3; i++) begin
                c[i] = base_x + $urandom_range(7);
                r[i] = base_y + $urandom_range(5);
            end
        end else if (pick >= 55 && pick < 65) begin
            for (i = 0; i < 3; i++) begin
                c[i] = $urandom_range((1 << COL_W) - 1);
                r[i] = $urandom_range((1 << ROW_W) - 1);
            end
        end else if (pick >= 65 && pick < 75) begin
            j = $urandom_range(2);
            r[(j + 1) % 3] = r[j];
        end else if (pick >= 75 && pick < 83) begin
            c[1] = c[0];
            c[2] = c[0];
        end else if (pick >= 83 && pick < 91) begin
            r[1] = r[0];
            r[2] = r[0];
        end else if (pick >= 91) begin
            base_x = $urandom_range(43);
            base_y = $urandom_range(17);
            step_x = $urandom_range(20);
            step_y = $urandom_range(15);
            for (i = 0; i < 3; i++) begin
                c[i] = base_x + i * step_x;
                r[i] = base_y + i * step_y;
            end
            if ($urandom_range(1)) begin
                c[1] = c[0];
                r[1] = r[0];
            end
        end
        send_tri(c[0], r[0], c[1], r[1], c[2], r[2]);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Points, including ones saturated from past the screen corner.
        send_tri(0, 0, 0, 0, 0, 0);
        send_tri(83, 47, 83, 47, 83, 47);
        send_tri(127, 63, 127, 63, 127, 63);
        // Vertical and horizontal lines.
        send_tri(10, 0, 10, 47, 10, 20);
        send_tri(0, 5, 83, 5, 40, 5);
        send_tri(127, 63, 0, 63, 50, 63);
        send_tri(100, 10, 127, 30, 90, 45);
        // Flat top and flat bottom edges.
        send_tri(10, 5, 40, 5, 25, 30);
        send_tri(60, 2, 20, 2, 5, 40);
        send_tri(30, 3, 5, 40, 70, 40);
        send_tri(0, 0, 0, 47, 83, 47);
        send_tri(83, 0, 0, 0, 83, 47);
        // Long edge on either side.
        send_tri(40, 0, 0, 30, 83, 47);
        send_tri(40, 0, 83, 30, 0, 47);
        send_tri(0, 0, 83, 20, 10, 47);
        send_tri(80, 0, 0, 47, 40, 10);
        // Collinear corners, a doubled corner, steep and shallow edges.
        send_tri(0, 0, 20, 20, 40, 40);
        send_tri(10, 10, 10, 10, 30, 40);
        send_tri(0, 0, 1, 47, 2, 20);
        send_tri(0, 20, 83, 21, 40, 22);
        send_tri(85, 42, 42, 21, 0, 63);

        repeat (137) send_random_tri();
        send_idle_pct = 62;
        recv_idle_pct = 30;
        repeat (137) send_random_tri();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (136) send_random_tri();
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (outstanding != 0) begin
            $error("%0d outline beats never arrived", outstanding);
        end
        $display("Sent %0d triangles (points, lines, flat edges, saturated corners, random shapes)",
                 sent_count);
        $display("under three sender/receiver stall mixes; %0d outline beats compared.",
                 beats_checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("triangle_outline_scanline_walker regression: pass");
        end else begin
            $display("triangle_outline_scanline_walker regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tosw_pkg.sv
hdl/tosw_divider.sv
hdl/tosw_datapath.sv
hdl/tosw_ctrl.sv
hdl/triangle_outline_scanline_walker.sv
sim/tosw_outline_checker.sv
sim/triangle_outline_scanline_walker_tb.sv
